// ===== rtl/rau_pkg.sv =====
// Shared types and constants of the rational arithmetic unit.
// Used by the top level, the reduction unit and the port checker.
package rau_pkg;

  localparam int WIDTH_DEF   = 16;
  localparam int OPER_W      = 16;  // operand fields on the input stream
  localparam int RES_N_W     = 16;  // result numerator field
  localparam int RES_D_W     = 15;  // result denominator field
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  // Extra magnitude bits of a cross product over the accumulator width.
  localparam int MAG_EXTRA   = 16;
  localparam int MAG_W_DEF   = WIDTH_DEF + MAG_EXTRA;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

endpackage

// ===== rtl/rau_reduce.sv =====
// Reduction unit: binary GCD of two magnitudes, then two restoring
// divisions that share one subtractor path. Depends on rau_pkg.
module rau_reduce import rau_pkg::*; #(
  parameter int MW = MAG_W_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] num_i,   // nonzero magnitude
  input  logic [MW-1:0] den_i,   // nonzero magnitude
  output logic          done_o,
  output logic [MW-1:0] num_o,
  output logic [MW-1:0] den_o
);

  localparam int KW = $clog2(MW);
  localparam int CW = $clog2(MW + 1);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_GCD  = 4'b0010,
    R_DIVN = 4'b0100,
    R_DIVD = 4'b1000
  } rstate_e;

  rstate_e       state_q, state_d;
  logic          done_q, done_d;
  logic [MW-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [MW-1:0] x_q, x_d, rem_q, rem_d, g_q, g_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [MW-1:0] num_q, num_d, den_q, den_d, qn_q, qn_d, qd_q, qd_d;

  logic          a_ge_b;
  logic [MW-1:0] diff;
  logic [MW:0]   rem_sh;
  logic          q_bit;
  logic [MW-1:0] rem_nx, x_nx;
  logic          last_bit;

  assign a_ge_b   = a_q >= b_q;
  assign diff     = a_ge_b ? (a_q - b_q) : (b_q - a_q);
  assign rem_sh   = {rem_q, x_q[MW-1]};
  assign q_bit    = rem_sh >= {1'b0, g_q};
  assign rem_nx   = q_bit ? MW'(rem_sh - {1'b0, g_q}) : rem_sh[MW-1:0];
  assign x_nx     = {x_q[MW-2:0], q_bit};
  assign last_bit = cnt_q == CW'(MW - 1);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    x_d     = x_q;
    rem_d   = rem_q;
    g_d     = g_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    den_d   = den_q;
    qn_d    = qn_q;
    qd_d    = qd_q;
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          a_d     = num_i;
          b_d     = den_i;
          num_d   = num_i;
          den_d   = den_i;
          k_d     = '0;
          state_d = R_GCD;
        end
      end
      R_GCD: begin
        if (a_q == '0 || b_q == '0) begin
          // Odd part of the GCD; the common power of two is removed by shifting.
          g_d     = a_q | b_q;
          x_d     = num_q >> k_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = R_DIVN;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_ge_b) begin
          a_d = diff >> 1;
        end else begin
          b_d = diff >> 1;
        end
      end
      R_DIVN: begin
        rem_d = rem_nx;
        x_d   = x_nx;
        cnt_d = cnt_q + 1'b1;
        if (last_bit) begin
          qn_d    = x_nx;
          x_d     = den_q >> k_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = R_DIVD;
        end
      end
      R_DIVD: begin
        rem_d = rem_nx;
        x_d   = x_nx;
        cnt_d = cnt_q + 1'b1;
        if (last_bit) begin
          qd_d    = x_nx;
          done_d  = 1'b1;
          state_d = R_IDLE;
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    x_q   <= x_d;
    rem_q <= rem_d;
    g_q   <= g_d;
    cnt_q <= cnt_d;
    num_q <= num_d;
    den_q <= den_d;
    qn_q  <= qn_d;
    qd_q  <= qd_d;
  end

  assign done_o = done_q;
  assign num_o  = qn_q;
  assign den_o  = qd_q;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: accumulator fraction updated by stream commands.
// Depends on rau_pkg and rau_reduce.
//
// Usage: each input word carries a command in s_axis_tuser and an operand
// fraction in s_axis_tdata. Commands load, add, subtract, multiply or divide
// the accumulator by the operand. Every input word yields one output word:
// the reduced accumulator (sign in the numerator, denominator positive) in
// m_axis_tdata and a status code in m_axis_tuser (ok, zero denominator or
// divide by zero, overflow). On a zero denominator, divide by zero,
// overflow or an unknown command the accumulator is left unchanged.
// One shared multiplier forms the three cross products in turn, then the
// reduction unit runs a binary GCD and two bit-serial divisions. A load
// skips the multiplier; error cases and unknown commands skip both.
// s_axis_tready is high only while no word is being worked on; the output
// register holds a finished word until m_axis_tready takes it, and the next
// input may be accepted meanwhile. Reset clears the accumulator to 0/1 and
// empties the output register.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] operand_numerator, [31:16] operand_denominator
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] command
  input  logic [CMD_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] result_numerator, [30:16] result_denominator, [31] zero padding
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [STATUS_W-1:0]    m_axis_tuser
);

  localparam int MW   = WIDTH + MAG_EXTRA;
  localparam int PRW  = WIDTH + 18;
  localparam int OPW  = OPER_W + 1;
  localparam int EXTW = (WIDTH > OPER_W) ? WIDTH : OPER_W;
  localparam int PADW = OUT_TDATA_W - RES_N_W - RES_D_W;
  localparam logic [MW-1:0] LIM = MW'(64'd1 << (WIDTH - 1));

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_NORM = 6'b000100,
    S_RED  = 6'b001000,
    S_CHK  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [1:0]              step_q, step_d;
  logic [CMD_W-1:0]        cmd_q, cmd_d;
  logic signed [OPW-1:0]   on_q, on_d, od_q, od_d;
  logic signed [PRW-1:0]   p_q, p_d;
  logic signed [MW:0]      n_q, n_d, d_q, d_d;
  logic                    neg_q, neg_d, zero_q, zero_d;
  status_e                 st_q, st_d;
  logic signed [WIDTH-1:0] acc_n_q, acc_n_d;
  logic [WIDTH-1:0]        acc_d_q, acc_d_d;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0]  m_data_q, m_data_d;
  status_e                 m_st_q, m_st_d;

  logic [CMD_W-1:0]        in_cmd;
  logic signed [OPW-1:0]   in_on, in_od, on_norm, od_norm;
  logic signed [WIDTH:0]   mul_a;
  logic signed [OPW-1:0]   mul_b;
  logic signed [PRW-1:0]   prod;
  logic signed [MW:0]      p_trunc;
  logic [MW-1:0]           nmag, dmag, qn, qd;
  logic                    red_start, red_done;
  logic [MW-1:0]           red_num, red_den;
  logic                    ovf;
  logic signed [EXTW-1:0]  n_ext;
  logic [EXTW-1:0]         d_ext;

  assign in_cmd  = s_axis_tuser;
  assign in_on   = OPW'($signed(s_axis_tdata[OPER_W-1:0]));
  assign in_od   = OPW'($signed(s_axis_tdata[2*OPER_W-1:OPER_W]));
  assign on_norm = in_od[OPW-1] ? -in_on : in_on;
  assign od_norm = in_od[OPW-1] ? -in_od : in_od;

  // Shared multiplier: step 0 forms the first numerator term, step 1 the
  // second (used by add and subtract), step 2 the denominator.
  always_comb begin
    mul_a = $signed({acc_n_q[WIDTH-1], acc_n_q});
    mul_b = od_q;
    case (step_q)
      2'd0: begin
        mul_a = $signed({acc_n_q[WIDTH-1], acc_n_q});
        mul_b = (cmd_q == CMD_MUL) ? on_q : od_q;
      end
      2'd1: begin
        mul_a = $signed({1'b0, acc_d_q});
        mul_b = on_q;
      end
      default: begin
        mul_a = $signed({1'b0, acc_d_q});
        mul_b = (cmd_q == CMD_DIV) ? on_q : od_q;
      end
    endcase
  end

  assign prod    = PRW'(mul_a) * PRW'(mul_b);
  assign p_trunc = $signed(p_q[MW:0]);

  assign nmag = n_q[MW] ? MW'(-n_q) : n_q[MW-1:0];
  assign dmag = d_q[MW] ? MW'(-d_q) : d_q[MW-1:0];

  assign red_start = (state_q == S_NORM) && (n_q != '0);

  rau_reduce #(
    .MW(MW)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(red_start),
    .num_i  (nmag),
    .den_i  (dmag),
    .done_o (red_done),
    .num_o  (red_num),
    .den_o  (red_den)
  );

  assign qn  = zero_q ? '0 : red_num;
  assign qd  = zero_q ? MW'(1) : red_den;
  assign ovf = (neg_q ? (qn > LIM) : (qn >= LIM)) || (qd >= LIM);

  assign n_ext = EXTW'(acc_n_q);
  assign d_ext = EXTW'(acc_d_q);

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cmd_d     = cmd_q;
    on_d      = on_q;
    od_d      = od_q;
    p_d       = p_q;
    n_d       = n_q;
    d_d       = d_q;
    neg_d     = neg_q;
    zero_d    = zero_q;
    st_d      = st_q;
    acc_n_d   = acc_n_q;
    acc_d_d   = acc_d_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_st_d    = m_st_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d  = in_cmd;
          on_d   = on_norm;
          od_d   = od_norm;
          step_d = '0;
          st_d   = ST_OK;
          n_d    = (MW + 1)'(on_norm);
          d_d    = (MW + 1)'(od_norm);
          if (in_cmd > CMD_DIV) begin
            state_d = S_DONE;
          end else if (in_od == '0) begin
            st_d    = ST_ZERO;
            state_d = S_DONE;
          end else if (in_cmd == CMD_DIV && in_on == '0) begin
            st_d    = ST_ZERO;
            state_d = S_DONE;
          end else if (in_cmd == CMD_LOAD) begin
            state_d = S_NORM;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        p_d    = prod;
        step_d = step_q + 1'b1;
        case (step_q)
          2'd1: n_d = p_trunc;
          2'd2: begin
            if (cmd_q == CMD_ADD) begin
              n_d = n_q + p_trunc;
            end else if (cmd_q == CMD_SUB) begin
              n_d = n_q - p_trunc;
            end
          end
          2'd3: begin
            d_d     = p_trunc;
            state_d = S_NORM;
          end
          default: ;
        endcase
      end
      S_NORM: begin
        neg_d  = n_q[MW] ^ d_q[MW];
        zero_d = n_q == '0;
        state_d = (n_q == '0) ? S_CHK : S_RED;
      end
      S_RED: begin
        if (red_done) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (ovf) begin
          st_d = ST_OVF;
        end else begin
          acc_n_d = WIDTH'(neg_q ? -qn : qn);
          acc_d_d = qd[WIDTH-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{PADW{1'b0}}, d_ext[RES_D_W-1:0], n_ext[RES_N_W-1:0]};
          m_st_d    = st_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      acc_n_q   <= '0;
      acc_d_q   <= WIDTH'(1);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      acc_n_q   <= acc_n_d;
      acc_d_q   <= acc_d_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    on_q     <= on_d;
    od_q     <= od_d;
    p_q      <= p_d;
    n_q      <= n_d;
    d_q      <= d_d;
    neg_q    <= neg_d;
    zero_q   <= zero_d;
    st_q     <= st_d;
    m_data_q <= m_data_d;
    m_st_q   <= m_st_d;
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_st_q;

endmodule

// ===== rtl/rau_checker.sv =====
// Port-level checks of the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg.
module rau_checker import rau_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]    m_axis_tuser
);

  // A stalled output word holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // Only one word is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_ZERO) ||
                      (m_axis_tuser == ST_OVF))
    else $error("undefined status code");

  // The reported accumulator denominator is nonzero (checked only when WIDTH <= RES_N_W).
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (WIDTH > RES_N_W) ||
                      (m_axis_tdata[RES_N_W+RES_D_W-1:RES_N_W] != '0))
    else $error("zero denominator reported");

endmodule

bind rational_arithmetic_unit rau_checker #(
  .WIDTH(WIDTH)
) u_rau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== tb/sv/rational_arithmetic_unit_tb.sv =====
// Self-checking testbench of the rational arithmetic unit: directed and random
// commands on the input stream, accumulator fractions predicted and compared.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam longint ACC_LIM    = longint'(1) << (WIDTH_DEF - 1);
  localparam int     N_RANDOM   = 550;
  localparam int     QUIET_TAIL = 60;   // last items sent with no idling
  localparam int     SETTLE     = 200;  // cycles after the last word

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [OPER_W-1:0] num;
    logic [OPER_W-1:0] den;
    bit                wait_idle;
  } command_t;

  typedef struct {
    logic [RES_N_W-1:0] num;
    logic [RES_D_W-1:0] den;
    status_e            status;
  } acc_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  command_t  command_q[$];
  acc_word_t acc_after_q[$];
  longint    acc_num = 0;
  longint    acc_den = 1;
  int        mismatch_cnt = 0;
  int        word_cnt = 0;
  int        src_gap = 0;
  int        sink_gap = 0;
  command_t  cur_cmd;
  acc_word_t want;

  rational_arithmetic_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint gcd_mag(longint a, longint b);
    longint t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Normalizes and reduces n/d; the accumulator only takes it if it fits.
  function automatic status_e commit_fraction(longint n, longint d);
    longint g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n == 0) begin
      d = 1;
    end else begin
      g = gcd_mag((n < 0) ? -n : n, d);
      n = n / g;
      d = d / g;
    end
    if (n < -ACC_LIM || n > ACC_LIM - 1 || d > ACC_LIM - 1) return ST_OVF;
    acc_num = n;
    acc_den = d;
    return ST_OK;
  endfunction

  task automatic step_accumulator(input logic [CMD_W-1:0] cmd,
                                  input logic [OPER_W-1:0] num_bits,
                                  input logic [OPER_W-1:0] den_bits);
    longint    op_n;
    longint    op_d;
    longint    an;
    longint    ad;
    status_e   st;
    acc_word_t w;
    op_n = longint'($signed(num_bits));
    op_d = longint'($signed(den_bits));
    an = acc_num;
    ad = acc_den;
    st = ST_OK;
    if (cmd <= CMD_DIV) begin
      if (op_d == 0) begin
        st = ST_ZERO;
      end else begin
        if (op_d < 0) begin
          op_n = -op_n;
          op_d = -op_d;
        end
        case (cmd)
          CMD_LOAD: st = commit_fraction(op_n, op_d);
          CMD_ADD:  st = commit_fraction(an * op_d + ad * op_n, ad * op_d);
          CMD_SUB:  st = commit_fraction(an * op_d - ad * op_n, ad * op_d);
          CMD_MUL:  st = commit_fraction(an * op_n, ad * op_d);
          default: begin
            if (op_n == 0) st = ST_ZERO;
            else st = commit_fraction(an * op_d, ad * op_n);
          end
        endcase
      end
    end
    w.num = acc_num[RES_N_W-1:0];
    w.den = acc_den[RES_D_W-1:0];
    w.status = st;
    acc_after_q.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    mismatch_cnt++;
    $display("mismatch on word %0d: %s is %0d, expected %0d", word_cnt, what, got, exp_val);
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int num, input int den,
                           input bit wait_idle);
    command_t c;
    c.cmd = cmd;
    c.num = num[OPER_W-1:0];
    c.den = den[OPER_W-1:0];
    c.wait_idle = wait_idle;
    command_q.push_back(c);
  endtask

  // Mostly small values so that chains of operations stay in range for a while.
  function automatic int random_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 120) - 60;
      6, 7:             return int'($signed($urandom_range(0, 65535) - 32768));
      8: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
      default:          return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  // Input side: one word in flight, presented again until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        step_accumulator(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (command_q.size() != 0 &&
                     !(command_q[0].wait_idle && acc_after_q.size() != 0)) begin
          cur_cmd = command_q.pop_front();
          s_axis_tuser  <= cur_cmd.cmd;
          s_axis_tdata  <= {cur_cmd.den, cur_cmd.num};
          s_axis_tvalid <= 1'b1;
          if (command_q.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
            src_gap = $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random back-pressure and the check of every word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        word_cnt++;
        if (acc_after_q.size() == 0) begin
          report_mismatch("word with nothing expected, numerator",
                          longint'($signed(m_axis_tdata[15:0])), 0);
        end else begin
          want = acc_after_q.pop_front();
          if (m_axis_tdata[15:0] !== want.num)
            report_mismatch("numerator", longint'($signed(m_axis_tdata[15:0])),
                            longint'($signed(want.num)));
          if (m_axis_tdata[30:16] !== want.den)
            report_mismatch("denominator", longint'(m_axis_tdata[30:16]), longint'(want.den));
          if (m_axis_tdata[31] !== 1'b0)
            report_mismatch("padding bit", longint'(m_axis_tdata[31]), 0);
          if (m_axis_tuser !== want.status)
            report_mismatch("status", longint'(m_axis_tuser), longint'(want.status));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (command_q.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
        sink_gap = $urandom_range(1, 17) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int r;
    logic [CMD_W-1:0] cmd;
    // Directed part: signs, extremes, zero denominators and overflow.
    queue_cmd(CMD_LOAD, 0, -5, 1'b0);
    queue_cmd(CMD_LOAD, 6, -4, 1'b0);
    queue_cmd(CMD_ADD, 1, 2, 1'b0);
    queue_cmd(CMD_SUB, 5, 3, 1'b0);
    queue_cmd(CMD_MUL, -7, 9, 1'b0);
    queue_cmd(CMD_DIV, 3, -11, 1'b0);
    queue_cmd(CMD_DIV, 0, 5, 1'b0);
    queue_cmd(CMD_LOAD, 9, 0, 1'b0);
    queue_cmd(CMD_ADD, 1, 0, 1'b0);
    queue_cmd(CMD_LOAD, 32767, 1, 1'b0);
    queue_cmd(CMD_ADD, 1, 1, 1'b0);
    queue_cmd(CMD_MUL, 32767, 1, 1'b0);
    queue_cmd(CMD_LOAD, -32768, 1, 1'b0);
    queue_cmd(CMD_SUB, 1, 1, 1'b0);
    queue_cmd(CMD_LOAD, 1, 32767, 1'b0);
    queue_cmd(CMD_LOAD, 1, -32768, 1'b0);
    queue_cmd(CMD_LOAD, -32768, -1, 1'b0);
    queue_cmd(CMD_LOAD, -32768, -32768, 1'b0);
    queue_cmd(CMD_DIV, -32768, 32767, 1'b0);
    // Codes above divide are ignored, with a zero denominator too.
    for (int c = int'(CMD_DIV) + 1; c < (1 << CMD_W); c++)
      queue_cmd(c[CMD_W-1:0], random_operand(), (c == (1 << CMD_W) - 1) ? 0 : 7, 1'b0);
    queue_cmd(CMD_LOAD, 32767, 32767, 1'b0);
    queue_cmd(CMD_MUL, -1, -1, 1'b0);
    queue_cmd(CMD_DIV, 7, 3, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4)       cmd = CMD_W'($urandom_range(int'(CMD_DIV) + 1, (1 << CMD_W) - 1));
      else if (r < 16) cmd = CMD_LOAD;
      else             cmd = CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_DIV)));
      queue_cmd(cmd, random_operand(),
                ($urandom_range(0, 29) == 0) ? 0 : random_operand(),
                (i % 110) == 0);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (command_q.size() != 0 || s_axis_tvalid || acc_after_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("PASS rational_arithmetic_unit");
    end else begin
      $display("FAIL rational_arithmetic_unit");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL rational_arithmetic_unit");
    $finish;
  end

endmodule
